>>> hdl/tpd_pkg.sv
`default_nettype none
package tpd_pkg;

  localparam int COORD_BITS = 12;
  localparam int WIDTH_BITS = 4;
  localparam int MAX_RES    = 3;

  localparam logic [1:0] KIND_CONTACT = 2'd0;
  localparam logic [1:0] KIND_NONE    = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
  } in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [WIDTH_BITS-1:0] touch_width;
    logic                  left_state;
    logic                  right_state;
    logic                  left_changed;
    logic                  right_changed;
    logic                  last;
  } out_t;

  // tracking state kept between packets
  typedef struct packed {
    logic [1:0]                  tracked;
    logic [1:0][COORD_BITS-1:0]  fx;
    logic [1:0][COORD_BITS-1:0]  fy;
    logic [1:0]                  known;
    logic                        left_held;
    logic                        right_held;
  } track_t;

endpackage
`default_nettype wire

>>> hdl/tpd_decode.sv
`default_nettype none
module tpd_decode (
  input  var tpd_pkg::in_t                 item,
  input  var tpd_pkg::track_t              st,
  input  wire [tpd_pkg::COORD_BITS-1:0]    y_max,
  output tpd_pkg::track_t                  st_nxt,
  output tpd_pkg::out_t [2:0]              res,
  output logic [1:0]                       res_cnt
);

  logic [1:0]                     fingers;
  logic [tpd_pkg::COORD_BITS-1:0] x;
  logic [tpd_pkg::COORD_BITS-1:0] raw_y;
  logic [tpd_pkg::COORD_BITS-1:0] y;
  logic [tpd_pkg::WIDTH_BITS-1:0] wid;
  logic                           slot;
  logic                           emit;
  logic [1:0]                     n;

  assign fingers = item.byte0[7:6];
  assign x       = {item.byte1[3:0], item.byte2};
  assign raw_y   = {item.byte4[3:0], item.byte5};
  assign y       = (raw_y > y_max) ? '0 : (y_max - raw_y);
  assign wid     = {item.byte0[5:4], item.byte3[5:4]};
  assign slot    = (item.byte0[3:2] == 2'b01) ? 1'b0 : 1'b1;

  always_comb begin
    st_nxt = st;
    res    = '0;
    n      = 2'd0;
    emit   = 1'b0;
    if (item.mode) begin
      if (st.tracked != 2'd0) begin
        st_nxt.tracked = 2'd0;
        res[0].kind    = tpd_pkg::KIND_NONE;
        n              = 2'd1;
      end
      if (st.tracked != 2'd0 || st.left_held || st.right_held) begin
        res[n].kind          = tpd_pkg::KIND_FRAME;
        res[n].left_changed  = st.left_held;
        res[n].right_changed = st.right_held;
        n                    = n + 2'd1;
      end
      st_nxt.left_held  = 1'b0;
      st_nxt.right_held = 1'b0;
    end else begin
      case (fingers)
        2'd0: begin
          st_nxt.tracked = 2'd0;
          emit           = 1'b1;
        end
        2'd1: begin
          st_nxt.tracked  = 2'd1;
          st_nxt.fx[0]    = x;
          st_nxt.fy[0]    = y;
          st_nxt.known[0] = 1'b1;
          emit            = 1'b1;
        end
        2'd2: begin
          if (st.tracked != 2'd2) begin
            st_nxt.tracked = 2'd2;
            st_nxt.known   = 2'b00;
          end
          st_nxt.fx[slot]    = x;
          st_nxt.fy[slot]    = y;
          st_nxt.known[slot] = 1'b1;
          emit               = (st_nxt.known == 2'b11);
        end
        default: begin
          // three fingers: dropped, state untouched
          emit = 1'b0;
        end
      endcase

      if (emit) begin
        if (st_nxt.tracked != 2'd0) begin
          res[0].kind        = tpd_pkg::KIND_CONTACT;
          res[0].pos_x       = st_nxt.fx[0];
          res[0].pos_y       = st_nxt.fy[0];
          res[0].touch_width = wid;
          n                  = 2'd1;
          if (st_nxt.tracked == 2'd2) begin
            res[1].kind        = tpd_pkg::KIND_CONTACT;
            res[1].pos_x       = st_nxt.fx[1];
            res[1].pos_y       = st_nxt.fy[1];
            res[1].touch_width = wid;
            n                  = 2'd2;
          end
        end else if (st.tracked != 2'd0) begin
          res[0].kind = tpd_pkg::KIND_NONE;
          n           = 2'd1;
        end
        res[n].kind          = tpd_pkg::KIND_FRAME;
        res[n].left_state    = item.byte0[0];
        res[n].right_state   = item.byte0[1];
        res[n].left_changed  = item.byte0[0] ^ st.left_held;
        res[n].right_changed = item.byte0[1] ^ st.right_held;
        st_nxt.left_held     = item.byte0[0];
        st_nxt.right_held    = item.byte0[1];
        n                    = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
    res_cnt = n;
  end

endmodule
`default_nettype wire

>>> hdl/touchpad_v2_packet_decoder.sv
// The first result of an item is offered in the cycle after its transfer.
// An item yields 0..3 results, offered one per cycle from the result buffer while
// out_stall is low; the next item transfers in the cycle the previous item's last
// result leaves, or at once when no results are held.
// Reset: synchronous, active-low rst_n; clears tracking, buttons, buffer; y_max = 4095.
`default_nettype none
module touchpad_v2_packet_decoder (
  input  wire                           clk,
  input  wire                           rst_n,
  // packet / release items
  input  wire                           in_valid,
  output logic                          in_stall,
  input  var tpd_pkg::in_t              in_data,
  // decoded results
  output logic                          out_valid,
  input  wire                           out_stall,
  output tpd_pkg::out_t                 out_data,
  // y_max register
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [tpd_pkg::COORD_BITS-1:0] cfg_data
);

  tpd_pkg::track_t                track_r, track_nxt;
  tpd_pkg::out_t [2:0]            res_r, res_nxt;
  logic [1:0]                     cnt_r;     // results held for current item
  logic [1:0]                     idx_r;     // next result to offer
  logic [1:0]                     dec_cnt;
  logic [tpd_pkg::COORD_BITS-1:0] y_max_r;

  logic in_xfer;
  logic out_xfer;
  logic drain_done;

  // Decode works straight off the input payload; results land in res_r.
  tpd_decode u_dec (
    .item    (in_data),
    .st      (track_r),
    .y_max   (y_max_r),
    .st_nxt  (track_nxt),
    .res     (res_nxt),
    .res_cnt (dec_cnt)
  );

  assign out_valid  = (cnt_r != 2'd0);
  assign out_data   = res_r[idx_r];
  assign out_xfer   = out_valid && !out_stall;
  // buffer frees up as the final result transfers
  assign drain_done = out_xfer && (idx_r == cnt_r - 2'd1);
  assign in_stall   = out_valid && !drain_done;
  assign in_xfer    = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      cnt_r   <= 2'd0;
      idx_r   <= 2'd0;
      y_max_r <= '1;
    end else begin
      if (cfg_valid) begin
        y_max_r <= cfg_data;
      end
      if (in_xfer) begin
        track_r <= track_nxt;
        cnt_r   <= dec_cnt;
        idx_r   <= 2'd0;
      end else if (drain_done) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else if (out_xfer) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
